@@ src/rau_pkg.sv @@
package rau_pkg;

   // Default data width of the fractions.
   localparam int WORD_BITS_DEF = 32;

   // Width of the operation code.
   localparam int MODE_BITS = 3;

   // Operation codes carried by the mode field.
   localparam logic [MODE_BITS-1:0] MODE_ADD      = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_SUB      = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_MUL      = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_DIV      = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_SIMPLIFY = 3'd4;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_MUL_LOAD,
      ST_MUL_RUN,
      ST_MUL_STORE,
      ST_GCD_LOAD,
      ST_GCD_RUN,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_DIV_STORE,
      ST_FINISH
   } state_type;

   // Datapath operations.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_PASS,
      OP_MUL_LOAD,
      OP_MUL_STEP,
      OP_MUL_STORE,
      OP_GCD_LOAD,
      OP_GCD_STEP,
      OP_GCD_LATCH,
      OP_DIV_LOAD,
      OP_DIV_STEP,
      OP_DIV_STORE,
      OP_OUT_LOAD
   } dp_op_type;

   // Operand pairs fed to the shift-add multiplier.
   typedef enum logic [2:0] {
      PAIR_AN_BD,
      PAIR_BN_AD,
      PAIR_AN_BN,
      PAIR_AD_BD,
      PAIR_AD_BN
   } pair_type;

   // Where a finished product or quotient is written.
   typedef enum logic [1:0] {
      DEST_RN_SET,
      DEST_RN_ADD,
      DEST_RN_SUB,
      DEST_RD_SET
   } dest_type;

   typedef struct packed {
      dp_op_type op;
      pair_type  pair;
      dest_type  dest;
   } dp_cmd_type;

   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic                 simp_ok;
      logic                 gcd_equal;
   } dp_sts_type;

   typedef struct packed {
      pair_type pair;
      dest_type dest;
      logic     last;
   } mul_plan_type;

   // Sequence of products for each arithmetic operation.
   function automatic mul_plan_type mul_plan(input logic [MODE_BITS-1:0] mode,
                                             input logic [1:0] step);
      mul_plan_type p;
      p = '{pair: PAIR_AN_BD, dest: DEST_RN_SET, last: 1'b1};
      unique case (mode)
         MODE_ADD, MODE_SUB: begin
            unique case (step)
               2'd0: p = '{pair: PAIR_AN_BD, dest: DEST_RN_SET, last: 1'b0};
               2'd1: p = '{pair: PAIR_BN_AD,
                           dest: (mode == MODE_ADD) ? DEST_RN_ADD : DEST_RN_SUB,
                           last: 1'b0};
               default: p = '{pair: PAIR_AD_BD, dest: DEST_RD_SET, last: 1'b1};
            endcase
         end
         MODE_MUL: begin
            if (step == 2'd0) begin
               p = '{pair: PAIR_AN_BN, dest: DEST_RN_SET, last: 1'b0};
            end else begin
               p = '{pair: PAIR_AD_BD, dest: DEST_RD_SET, last: 1'b1};
            end
         end
         MODE_DIV: begin
            if (step == 2'd0) begin
               p = '{pair: PAIR_AN_BD, dest: DEST_RN_SET, last: 1'b0};
            end else begin
               p = '{pair: PAIR_AD_BN, dest: DEST_RD_SET, last: 1'b1};
            end
         end
         default: begin
            p = '{pair: PAIR_AN_BD, dest: DEST_RN_SET, last: 1'b1};
         end
      endcase
      return p;
   endfunction

endpackage

@@ src/rau_dp.sv @@
module rau_dp #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
   input  logic                               clock,
   input  rau_pkg::dp_cmd_type                cmd,
   output rau_pkg::dp_sts_type                sts,
   input  logic        [rau_pkg::MODE_BITS-1:0] req_mode,
   input  logic signed [WORD_BITS-1:0]        req_a_num,
   input  logic signed [WORD_BITS-1:0]        req_a_den,
   input  logic signed [WORD_BITS-1:0]        req_b_num,
   input  logic signed [WORD_BITS-1:0]        req_b_den,
   output logic signed [WORD_BITS-1:0]        rsp_r_num,
   output logic signed [WORD_BITS-1:0]        rsp_r_den
);
   import rau_pkg::*;

   localparam int KW = $clog2(WORD_BITS);

   logic [MODE_BITS-1:0] mode_ff, mode_in;
   logic [WORD_BITS-1:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [WORD_BITS-1:0] opa_ff, opa_in, opb_ff, opb_in, acc_ff, acc_in;
   logic [WORD_BITS-1:0] g_ff, g_in, rn_ff, rn_in, rd_ff, rd_in;
   logic [WORD_BITS-1:0] out_num_ff, out_num_in, out_den_ff, out_den_in;
   logic [KW-1:0]        k_ff, k_in;

   logic [WORD_BITS-1:0] pair_x, pair_y, store_val;
   logic [WORD_BITS:0]   div_shift, div_diff;
   logic                 div_ge;

   // Operand pair selection for the multiplier.
   always_comb begin
      unique case (cmd.pair)
         PAIR_AN_BD: begin pair_x = an_ff; pair_y = bd_ff; end
         PAIR_BN_AD: begin pair_x = bn_ff; pair_y = ad_ff; end
         PAIR_AN_BN: begin pair_x = an_ff; pair_y = bn_ff; end
         PAIR_AD_BD: begin pair_x = ad_ff; pair_y = bd_ff; end
         PAIR_AD_BN: begin pair_x = ad_ff; pair_y = bn_ff; end
         default:    begin pair_x = an_ff; pair_y = bd_ff; end
      endcase
   end

   // One restoring division step: shift in the next dividend bit and trial subtract.
   assign div_shift = {acc_ff, opa_ff[WORD_BITS-1]};
   assign div_diff  = div_shift - {1'b0, opb_ff};
   assign div_ge    = ~div_diff[WORD_BITS];

   // A product comes from the accumulator, a quotient from the dividend register.
   assign store_val = (cmd.op == OP_DIV_STORE) ? opa_ff : acc_ff;

   // Next values of the working registers.
   always_comb begin
      mode_in    = mode_ff;
      an_in      = an_ff;
      ad_in      = ad_ff;
      bn_in      = bn_ff;
      bd_in      = bd_ff;
      opa_in     = opa_ff;
      opb_in     = opb_ff;
      acc_in     = acc_ff;
      g_in       = g_ff;
      k_in       = k_ff;
      rn_in      = rn_ff;
      rd_in      = rd_ff;
      out_num_in = out_num_ff;
      out_den_in = out_den_ff;
      unique case (cmd.op)
         OP_CAPTURE: begin
            mode_in = req_mode;
            an_in   = $unsigned(req_a_num);
            ad_in   = $unsigned(req_a_den);
            bn_in   = $unsigned(req_b_num);
            bd_in   = $unsigned(req_b_den);
         end
         OP_PASS: begin
            rn_in = an_ff;
            rd_in = ad_ff;
         end
         OP_MUL_LOAD: begin
            opa_in = pair_x;
            opb_in = pair_y;
            acc_in = '0;
         end
         OP_MUL_STEP: begin
            if (opb_ff[0]) begin
               acc_in = acc_ff + opa_ff;
            end
            opa_in = {opa_ff[WORD_BITS-2:0], 1'b0};
            opb_in = {1'b0, opb_ff[WORD_BITS-1:1]};
         end
         OP_MUL_STORE, OP_DIV_STORE: begin
            unique case (cmd.dest)
               DEST_RN_SET: rn_in = store_val;
               DEST_RN_ADD: rn_in = rn_ff + store_val;
               DEST_RN_SUB: rn_in = rn_ff - store_val;
               DEST_RD_SET: rd_in = store_val;
               default:     rn_in = store_val;
            endcase
         end
         OP_GCD_LOAD: begin
            opa_in = an_ff;
            opb_in = ad_ff;
            k_in   = '0;
         end
         OP_GCD_STEP: begin
            // Binary gcd: strip common twos, then odd parts, then subtract.
            priority if (!opa_ff[0] && !opb_ff[0]) begin
               opa_in = {1'b0, opa_ff[WORD_BITS-1:1]};
               opb_in = {1'b0, opb_ff[WORD_BITS-1:1]};
               k_in   = k_ff + 1'b1;
            end else if (!opa_ff[0]) begin
               opa_in = {1'b0, opa_ff[WORD_BITS-1:1]};
            end else if (!opb_ff[0]) begin
               opb_in = {1'b0, opb_ff[WORD_BITS-1:1]};
            end else if (opa_ff > opb_ff) begin
               opa_in = opa_ff - opb_ff;
            end else begin
               opb_in = opb_ff - opa_ff;
            end
         end
         OP_GCD_LATCH: begin
            g_in = opa_ff << k_ff;
         end
         OP_DIV_LOAD: begin
            opa_in = (cmd.dest == DEST_RD_SET) ? ad_ff : an_ff;
            opb_in = g_ff;
            acc_in = '0;
         end
         OP_DIV_STEP: begin
            acc_in = div_ge ? div_diff[WORD_BITS-1:0] : div_shift[WORD_BITS-1:0];
            opa_in = {opa_ff[WORD_BITS-2:0], div_ge};
         end
         OP_OUT_LOAD: begin
            out_num_in = rn_ff;
            out_den_in = rd_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      opa_ff     <= opa_in;
      opb_ff     <= opb_in;
      acc_ff     <= acc_in;
      g_ff       <= g_in;
      k_ff       <= k_in;
      rn_ff      <= rn_in;
      rd_ff      <= rd_in;
      out_num_ff <= out_num_in;
      out_den_ff <= out_den_in;
   end

   // Status back to the controller.
   assign sts.mode      = mode_ff;
   assign sts.simp_ok   = (an_ff != '0) && !an_ff[WORD_BITS-1] &&
                          (ad_ff != '0) && !ad_ff[WORD_BITS-1];
   assign sts.gcd_equal = (opa_ff == opb_ff);

   assign rsp_r_num = $signed(out_num_ff);
   assign rsp_r_den = $signed(out_den_ff);

endmodule

@@ src/rau_ctrl.sv @@
module rau_ctrl #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rau_pkg::dp_sts_type sts,
   output rau_pkg::dp_cmd_type cmd
);
   import rau_pkg::*;

   localparam int CW = $clog2(WORD_BITS);
   localparam logic [CW-1:0] CNT_LAST = CW'(WORD_BITS - 1);

   state_type    state_ff, state_in;
   logic [1:0]   step_ff, step_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic         out_valid_ff, out_valid_in;
   logic         out_free, is_arith, is_simplify;
   mul_plan_type plan;

   assign out_free    = !out_valid_ff || rsp_ready;
   assign is_arith    = (sts.mode == MODE_ADD) || (sts.mode == MODE_SUB) ||
                        (sts.mode == MODE_MUL) || (sts.mode == MODE_DIV);
   assign is_simplify = (sts.mode == MODE_SIMPLIFY) && sts.simp_ok;
   assign plan        = mul_plan(sts.mode, step_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            priority if (is_arith) begin
               state_in = ST_MUL_LOAD;
            end else if (is_simplify) begin
               state_in = ST_GCD_LOAD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MUL_LOAD:  state_in = ST_MUL_RUN;
         ST_MUL_RUN:   if (cnt_ff == CNT_LAST) state_in = ST_MUL_STORE;
         ST_MUL_STORE: state_in = plan.last ? ST_FINISH : ST_MUL_LOAD;
         ST_GCD_LOAD:  state_in = ST_GCD_RUN;
         ST_GCD_RUN:   if (sts.gcd_equal) state_in = ST_DIV_LOAD;
         ST_DIV_LOAD:  state_in = ST_DIV_RUN;
         ST_DIV_RUN:   if (cnt_ff == CNT_LAST) state_in = ST_DIV_STORE;
         ST_DIV_STORE: state_in = step_ff[0] ? ST_FINISH : ST_DIV_LOAD;
         ST_FINISH:    if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd = '{op: OP_NONE, pair: PAIR_AN_BD, dest: DEST_RN_SET};
      unique case (state_ff)
         ST_IDLE:      if (req_valid) cmd.op = OP_CAPTURE;
         ST_DISPATCH:  if (!is_arith && !is_simplify) cmd.op = OP_PASS;
         ST_MUL_LOAD: begin
            cmd.op   = OP_MUL_LOAD;
            cmd.pair = plan.pair;
         end
         ST_MUL_RUN:   cmd.op = OP_MUL_STEP;
         ST_MUL_STORE: begin
            cmd.op   = OP_MUL_STORE;
            cmd.dest = plan.dest;
         end
         ST_GCD_LOAD:  cmd.op = OP_GCD_LOAD;
         ST_GCD_RUN:   cmd.op = sts.gcd_equal ? OP_GCD_LATCH : OP_GCD_STEP;
         ST_DIV_LOAD: begin
            cmd.op   = OP_DIV_LOAD;
            cmd.dest = step_ff[0] ? DEST_RD_SET : DEST_RN_SET;
         end
         ST_DIV_RUN:   cmd.op = OP_DIV_STEP;
         ST_DIV_STORE: begin
            cmd.op   = OP_DIV_STORE;
            cmd.dest = step_ff[0] ? DEST_RD_SET : DEST_RN_SET;
         end
         ST_FINISH:    if (out_free) cmd.op = OP_OUT_LOAD;
         default:      cmd.op = OP_NONE;
      endcase
   end

   // Step and bit counters, and the output valid flag.
   always_comb begin
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      unique case (state_ff)
         ST_DISPATCH:               step_in = '0;
         ST_MUL_LOAD, ST_DIV_LOAD:  cnt_in  = '0;
         ST_MUL_RUN, ST_DIV_RUN:    cnt_in  = cnt_ff + 1'b1;
         ST_MUL_STORE, ST_DIV_STORE: step_in = step_ff + 1'b1;
         default: begin
         end
      endcase
      if (state_ff == ST_FINISH && out_free) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

endmodule

@@ src/rational_arithmetic_unit.sv @@
// One word at a time. Add and subtract use three products, multiply and divide two,
// each from one pass of the shift-add multiplier. Simplify runs a binary gcd search
// and then two restoring divisions; other cases pass the first fraction through.
// The next word is taken once the current result sits in the output register.
// Synchronous active-high reset clears the controller and the output valid flag.
module rational_arithmetic_unit #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic        [rau_pkg::MODE_BITS-1:0] req_mode,
   input  logic signed [WORD_BITS-1:0]         req_a_num,
   input  logic signed [WORD_BITS-1:0]         req_a_den,
   input  logic signed [WORD_BITS-1:0]         req_b_num,
   input  logic signed [WORD_BITS-1:0]         req_b_den,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [WORD_BITS-1:0]         rsp_r_num,
   output logic signed [WORD_BITS-1:0]         rsp_r_den
);
   import rau_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   rau_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rau_dp #(.WORD_BITS(WORD_BITS)) u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .sts       (sts),
      .req_mode  (req_mode),
      .req_a_num (req_a_num),
      .req_a_den (req_a_den),
      .req_b_num (req_b_num),
      .req_b_den (req_b_den),
      .rsp_r_num (rsp_r_num),
      .rsp_r_den (rsp_r_den)
   );

   // A word is captured exactly when it is accepted.
   a_capture_on_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_CAPTURE) == (req_valid && req_ready))
      else $error("operand capture does not match input acceptance");

   // Once a word is taken, the unit is busy in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input ready while a word is in flight");

   // The gcd search only starts on two positive parts.
   a_gcd_operands: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_GCD_LOAD) |-> sts.simp_ok)
      else $error("gcd started on a non-positive fraction");

   // A gcd step is never issued once the two values have met.
   a_gcd_stop: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_GCD_STEP) |-> !sts.gcd_equal)
      else $error("gcd step after convergence");

endmodule

@@ bench/fraction_checker.sv @@
`timescale 1ns / 100ps

module fraction_checker #(
   parameter int W = rau_pkg::WORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [rau_pkg::MODE_BITS-1:0] req_mode,
   input  logic [W-1:0]                  req_a_num,
   input  logic [W-1:0]                  req_a_den,
   input  logic [W-1:0]                  req_b_num,
   input  logic [W-1:0]                  req_b_den,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [W-1:0]                  rsp_r_num,
   input  logic [W-1:0]                  rsp_r_den,
   input  logic                          run_over,
   output int unsigned                   mismatches
);

   import rau_pkg::*;

   typedef struct packed {
      logic [W-1:0] num;
      logic [W-1:0] den;
   } fraction_type;

   fraction_type expected_fractions[$];
   logic         leftovers_checked = 1'b0;

   // A part counts as positive when it is non-zero and its sign bit is clear.
   function automatic logic is_positive(input logic [W-1:0] v);
      return !v[W-1] && (v != '0);
   endfunction

   // Works out the fraction that one word should produce; all products wrap to W bits.
   function automatic fraction_type combine_fractions(input logic [MODE_BITS-1:0] mode,
                                                      input logic [W-1:0] an,
                                                      input logic [W-1:0] ad,
                                                      input logic [W-1:0] bn,
                                                      input logic [W-1:0] bd);
      fraction_type r;
      logic [W-1:0] x;
      logic [W-1:0] y;
      logic [W-1:0] t;
      r = '{num: an, den: ad};
      case (mode)
         MODE_ADD: begin
            r.num = an * bd + bn * ad;
            r.den = ad * bd;
         end
         MODE_SUB: begin
            r.num = an * bd - bn * ad;
            r.den = ad * bd;
         end
         MODE_MUL: begin
            r.num = an * bn;
            r.den = ad * bd;
         end
         MODE_DIV: begin
            r.num = an * bd;
            r.den = ad * bn;
         end
         MODE_SIMPLIFY: begin
            // Reduction happens only when both parts are positive; a remainder loop
            // gives the divisor.
            if (is_positive(an) && is_positive(ad)) begin
               x = an;
               y = ad;
               while (y != '0) begin
                  t = x % y;
                  x = y;
                  y = t;
               end
               r.num = an / x;
               r.den = ad / x;
            end
         end
         default: begin
            // The spare codes hand the first fraction back untouched.
            r = '{num: an, den: ad};
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      mismatches = mismatches + 1;
   endtask

   // Each accepted request word queues its prediction; each accepted result word is
   // checked against the oldest one still waiting.
   always @(posedge clock) begin : watch
      fraction_type want;
      if (reset) begin
         mismatches = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_fractions.push_back(combine_fractions(req_mode, req_a_num, req_a_den,
                                                           req_b_num, req_b_den));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_fractions.size() == 0) begin
               report_mismatch($sformatf("unexpected result word %h/%h",
                                         rsp_r_num, rsp_r_den));
            end else begin
               want = expected_fractions.pop_front();
               if (rsp_r_num !== want.num) begin
                  report_mismatch($sformatf("r_num got %h want %h", rsp_r_num, want.num));
               end
               if (rsp_r_den !== want.den) begin
                  report_mismatch($sformatf("r_den got %h want %h", rsp_r_den, want.den));
               end
            end
         end
         if (run_over && !leftovers_checked) begin
            leftovers_checked <= 1'b1;
            if (expected_fractions.size() != 0) begin
               report_mismatch($sformatf("%0d result words never arrived",
                                         expected_fractions.size()));
            end
         end
      end
   end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;

   import rau_pkg::*;

   localparam int          W             = WORD_BITS_DEF;
   localparam int          RANDOM_WORDS  = 650;
   localparam int          SETTLE_CYCLES = 5 * W + 16;
   localparam int          LIMIT_CYCLES  = 750_000;
   localparam int          MAX_GAP       = 11;
   localparam logic [W-1:0] INT_MAX      = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] INT_MIN      = {1'b1, {(W-1){1'b0}}};
   localparam int          LAST_MODE     = (1 << MODE_BITS) - 1;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [MODE_BITS-1:0] req_mode  = MODE_ADD;
   logic [W-1:0]         req_a_num = '0;
   logic [W-1:0]         req_a_den = '0;
   logic [W-1:0]         req_b_num = '0;
   logic [W-1:0]         req_b_den = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [W-1:0]         rsp_r_num;
   logic [W-1:0]         rsp_r_den;
   logic                 run_over  = 1'b0;
   int unsigned          mismatches;

   int unsigned          words_sent = 0;
   int unsigned          words_back = 0;
   int unsigned          rsp_wait   = 0;
   logic                 rsp_fire   = 1'b0;
   int unsigned          cycles     = 0;

   rational_arithmetic_unit #(
      .WORD_BITS(W)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode (req_mode),
      .req_a_num(req_a_num),
      .req_a_den(req_a_den),
      .req_b_num(req_b_num),
      .req_b_den(req_b_den),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_r_num(rsp_r_num),
      .rsp_r_den(rsp_r_den)
   );

   fraction_checker #(
      .W(W)
   ) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .req_a_num (req_a_num),
      .req_a_den (req_a_den),
      .req_b_num (req_b_num),
      .req_b_den (req_b_den),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_r_num (rsp_r_num),
      .rsp_r_den (rsp_r_den),
      .run_over  (run_over),
      .mismatches(mismatches)
   );

   always #1 clock = ~clock;

   // Runaway guard.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Note each result word taken so the receiving side can plan its next stall.
   always @(posedge clock) begin
      rsp_fire <= !reset && rsp_valid && rsp_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         words_back <= words_back + 1;
      end
   end

   // Receiving side: after each word it holds ready low for a random stall, with
   // stretches of no stall at all.
   always @(negedge clock) begin : rsp_side
      int unsigned gap;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 1;
      end else if (rsp_fire) begin
         gap = (words_back % 70 < 15) ? 0 : $urandom_range(0, MAX_GAP);
         rsp_ready <= (gap == 0);
         rsp_wait  <= gap;
      end else if (rsp_wait != 0) begin
         rsp_ready <= (rsp_wait == 1);
         rsp_wait  <= rsp_wait - 1;
      end
   end

   // Offers one request word after a random gap and holds it until it is taken.
   task automatic send_word(input logic [MODE_BITS-1:0] mode,
                            input logic [W-1:0] an, input logic [W-1:0] ad,
                            input logic [W-1:0] bn, input logic [W-1:0] bd);
      int unsigned gap;
      gap = (words_sent % 80 < 20) ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode  <= mode;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      words_sent = words_sent + 1;
   endtask

   // Operand mix: mostly full-range or positive words, then small signed values and the extremes.
   function automatic logic [W-1:0] pick_operand();
      logic [W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4, 5, 6:    v = $urandom_range(0, 40) - 20;
         7: begin
            case ($urandom_range(0, 4))
               0:       v = '0;
               1:       v = 1;
               2:       v = '1;
               3:       v = INT_MAX;
               default: v = INT_MIN;
            endcase
         end
         default:    v = $urandom_range(1, INT_MAX);
      endcase
      return v;
   endfunction

   function automatic logic [MODE_BITS-1:0] pick_mode();
      int unsigned r;
      r = $urandom_range(0, 15);
      if (r <= MODE_SIMPLIFY) begin
         return MODE_BITS'(r);
      end else if (r < 9) begin
         return MODE_SIMPLIFY;
      end else begin
         return MODE_BITS'($urandom_range(0, LAST_MODE));
      end
   endfunction

   initial begin : stimulus
      logic [MODE_BITS-1:0] mode;
      logic [W-1:0]         an;
      logic [W-1:0]         ad;
      logic [W-1:0]         bn;
      logic [W-1:0]         bd;
      int unsigned          g;
      int unsigned          span;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed words: ordinary cases of each operation first.
      send_word(MODE_ADD, 1, 2, 1, 3);
      send_word(MODE_SUB, 1, 2, 1, 3);
      send_word(MODE_MUL, 2, 3, 3, 4);
      send_word(MODE_DIV, 2, 3, 3, 4);
      send_word(MODE_SIMPLIFY, 12, 18, INT_MIN, INT_MAX);
      // Simplify leaves a fraction alone when a part is negative or zero.
      send_word(MODE_SIMPLIFY, -6, 4, 5, 7);
      send_word(MODE_SIMPLIFY, 6, -4, 5, 7);
      send_word(MODE_SIMPLIFY, 6, 0, 5, 7);
      send_word(MODE_SIMPLIFY, 0, 5, 5, 7);
      send_word(MODE_SIMPLIFY, INT_MIN, INT_MIN, '1, '1);
      // Simplify at the top of the positive range, and with coprime parts.
      send_word(MODE_SIMPLIFY, INT_MAX, INT_MAX, 0, 0);
      send_word(MODE_SIMPLIFY, INT_MAX, 1, 0, 0);
      send_word(MODE_SIMPLIFY, 2147483629, 2147483587, 0, 0);
      // Wrapping products and sums.
      send_word(MODE_ADD, INT_MIN, INT_MIN, INT_MIN, INT_MIN);
      send_word(MODE_SUB, INT_MAX, INT_MAX, INT_MAX, INT_MAX);
      send_word(MODE_MUL, INT_MIN, INT_MAX, INT_MIN, INT_MAX);
      send_word(MODE_ADD, '1, '1, '1, '1);
      send_word(MODE_MUL, '1, INT_MAX, INT_MIN, '1);
      // Zero denominators and a zero divisor get no special handling.
      send_word(MODE_DIV, 5, 7, 0, 3);
      send_word(MODE_ADD, 5, 0, 3, 0);
      send_word(MODE_SUB, 0, 0, 0, 0);
      // Spare mode codes return the first fraction.
      for (int m = MODE_SIMPLIFY + 1; m <= LAST_MODE; m++) begin
         send_word(MODE_BITS'(m), INT_MIN, INT_MAX, '1, 1);
      end

      // Random words; simplify mostly gets positive pairs sharing a factor.
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         mode = pick_mode();
         an   = pick_operand();
         ad   = pick_operand();
         bn   = pick_operand();
         bd   = pick_operand();
         if (mode == MODE_SIMPLIFY && $urandom_range(0, 2) != 0) begin
            span = ($urandom_range(0, 1) != 0) ? 1000 : 46340;
            g    = $urandom_range(1, span);
            an   = g * $urandom_range(1, span);
            ad   = g * $urandom_range(1, span);
         end
         // Let the block drain completely now and then before carrying on.
         if (i % 200 == 100) begin
            wait (words_back == words_sent);
         end
         send_word(mode, an, ad, bn, bd);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (words_back == words_sent);
      repeat (SETTLE_CYCLES) @(negedge clock);
      run_over <= 1'b1;
      repeat (2) @(posedge clock);

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
